// ----- hdl/tnps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the two-nearest point search core.
// No dependencies; every other file of the block imports this package.
package tnps_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int COORD_W     = 16;
    localparam int IDX_W       = 7;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int DIST_W      = 34;
    localparam int DOT_W       = 36;
    localparam int ORIGIN_W    = 3 * COORD_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DIST_W-1:0] RADIUS_SQ_RESET = DIST_W'(999999);

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ   = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [SLOT_W-1:0]         entry_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic signed [COORD_W-1:0] plane_offset;
        logic                      plane_flip;
        logic                      use_plane;
    } req_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic             used_fallback;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_CMP,
        ST_FIN
    } state_t;

    // one multiply per step: three squared differences, then three dot terms
    typedef enum logic [2:0] {
        OP_SQ_X  = 3'd0,
        OP_SQ_Y  = 3'd1,
        OP_SQ_Z  = 3'd2,
        OP_DOT_X = 3'd3,
        OP_DOT_Y = 3'd4,
        OP_DOT_Z = 3'd5
    } mac_op_t;

    typedef struct packed {
        logic    clear;
        logic    mul_en;
        mac_op_t op;
    } mac_ctrl_t;

endpackage

// ----- hdl/tnps_mac.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: squared distance and plane dot product
// of one entry, one multiply per cycle. Depends on tnps_pkg.
module tnps_mac
    import tnps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 ctrl,
    input  req_item_t                 query,
    input  logic [ORIGIN_W-1:0]       origin,
    output logic [DIST_W-1:0]         dist_sq,
    output logic signed [DOT_W-1:0]   dot
);

    logic signed [COORD_W-1:0] org_x, org_y, org_z;
    logic signed [COORD_W:0]   op_a, op_b;
    logic signed [2*COORD_W+1:0] prod_next, prod_reg;
    mac_op_t                   op_reg;
    logic                      prod_vld_reg;
    logic [DIST_W-1:0]         dist_acc_reg, dist_acc_next;
    logic signed [DOT_W-1:0]   dot_acc_reg, dot_acc_next;

    assign org_x = origin[3*COORD_W-1:2*COORD_W];
    assign org_y = origin[2*COORD_W-1:COORD_W];
    assign org_z = origin[COORD_W-1:0];

    always_comb
    begin
        case (ctrl.op)
            OP_SQ_X:
            begin
                op_a = {org_x[COORD_W-1], org_x} - {query.pos_x[COORD_W-1], query.pos_x};
                op_b = op_a;
            end
            OP_SQ_Y:
            begin
                op_a = {org_y[COORD_W-1], org_y} - {query.pos_y[COORD_W-1], query.pos_y};
                op_b = op_a;
            end
            OP_SQ_Z:
            begin
                op_a = {org_z[COORD_W-1], org_z} - {query.pos_z[COORD_W-1], query.pos_z};
                op_b = op_a;
            end
            OP_DOT_X:
            begin
                op_a = {query.normal_x[COORD_W-1], query.normal_x};
                op_b = {org_x[COORD_W-1], org_x};
            end
            OP_DOT_Y:
            begin
                op_a = {query.normal_y[COORD_W-1], query.normal_y};
                op_b = {org_y[COORD_W-1], org_y};
            end
            OP_DOT_Z:
            begin
                op_a = {query.normal_z[COORD_W-1], query.normal_z};
                op_b = {org_z[COORD_W-1], org_z};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_comb
    begin
        dist_acc_next = dist_acc_reg;
        dot_acc_next  = dot_acc_reg;
        if (ctrl.clear)
        begin
            dist_acc_next = '0;
            // start the dot sum at -offset scaled to Q1.14
            dot_acc_next  = -(DOT_W'(query.plane_offset) <<< 14);
        end
        else if (prod_vld_reg)
        begin
            case (op_reg)
                OP_SQ_X, OP_SQ_Y, OP_SQ_Z:
                    dist_acc_next = dist_acc_reg + prod_reg[DIST_W-1:0];
                default:
                    dot_acc_next = dot_acc_reg + DOT_W'(prod_reg);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        op_reg       <= ctrl.op;
        dist_acc_reg <= dist_acc_next;
        dot_acc_reg  <= dot_acc_next;
    end

    assign dist_sq = dist_acc_reg;
    assign dot     = dot_acc_reg;

endmodule

// ----- hdl/tnps_rank.sv -----
`timescale 1ns / 1ps
// Running two-best tracker: keeps the nearest and second nearest candidate
// below the radius, earlier index winning ties. Depends on tnps_pkg.
module tnps_rank
    import tnps_pkg::*;
#(
    parameter int CW      = 7,
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              init,
    input  logic              upd,
    input  logic              cand_ok,
    input  logic [DIST_W-1:0] cand_dist,
    input  logic [CW-1:0]     cand_idx,
    input  logic [DIST_W-1:0] radius_sq,
    output logic [CW-1:0]     first_idx,
    output logic [CW-1:0]     second_idx
);

    localparam logic [CW-1:0] NONE = CW'(ENTRIES);

    logic [DIST_W-1:0] d1_reg, d1_next, d2_reg, d2_next;
    logic [CW-1:0]     i1_reg, i1_next, i2_reg, i2_next;

    always_comb
    begin
        d1_next = d1_reg;
        d2_next = d2_reg;
        i1_next = i1_reg;
        i2_next = i2_reg;
        if (init)
        begin
            d1_next = radius_sq;
            d2_next = radius_sq;
            i1_next = NONE;
            i2_next = NONE;
        end
        else if (upd && cand_ok)
        begin
            if (cand_dist < d1_reg)
            begin
                d2_next = d1_reg;
                i2_next = i1_reg;
                d1_next = cand_dist;
                i1_next = cand_idx;
            end
            else if (cand_dist < d2_reg)
            begin
                d2_next = cand_dist;
                i2_next = cand_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i1_reg <= NONE;
            i2_reg <= NONE;
        end
        else
        begin
            i1_reg <= i1_next;
            i2_reg <= i2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg <= d1_next;
        d2_reg <= d2_next;
    end

    assign first_idx  = i1_reg;
    assign second_idx = i2_reg;

endmodule

// ----- hdl/two_nearest_point_search_core.sv -----
`timescale 1ns / 1ps
// Top level of the two-nearest point search core: entry table, sequencer,
// response register. Depends on tnps_pkg, tnps_mac and tnps_rank.
//
// Load items write one entry origin into the table; the core stays idle.
// A query item scans entries 0 .. min(entry_count, ENTRIES)-1 once, keeping
// the two nearest of all entries and the two nearest front-side entries at
// the same time, so the plane-free fallback needs no second scan. Every
// entry goes through one shared 17x17 multiplier: a table read (READ), one
// multiply per term plus one step to drain the product (MAC), and a rank
// update (CMP); req_ready is low while a query runs. A finished result
// waits in the response register while the next item is taken; a query
// that finishes while that register is still full holds until it is
// drained. Configuration writes are always accepted and must only arrive
// while the core is idle.
module two_nearest_point_search_core
    import tnps_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_item_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_item_t            rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] NONE = CW'(ENTRIES);

    // configuration
    logic [COUNT_W-1:0] entry_count_reg;
    logic [DIST_W-1:0]  radius_sq_reg;

    // sequencer
    state_t         state_reg, state_next;
    logic [CW-1:0]  n_reg, idx_reg;
    logic [2:0]     step_reg;
    req_item_t      q_reg;
    mac_op_t        last_op;
    logic [2:0]     done_step;

    // entry table
    logic [ORIGIN_W-1:0] mem [ENTRIES];
    logic [ORIGIN_W-1:0] rd_data_reg;
    logic                rd_en;
    logic                mem_we;

    // datapath links
    mac_ctrl_t              mac_ctrl;
    logic [DIST_W-1:0]      dist_sq;
    logic signed [DOT_W-1:0] dot;
    logic                   front;
    logic                   rank_init, rank_upd;
    logic [CW-1:0]          fr_first, fr_second, al_first, al_second;

    // response
    logic       rsp_valid_reg;
    rsp_item_t  rsp_reg;
    rsp_item_t  result;
    logic       rsp_load;
    logic       req_acc;
    logic       scan_last;

    assign cfg_ready = 1'b1;
    assign req_acc   = req_valid && req_ready;
    assign mem_we    = req_acc && (req.req_type == REQ_LOAD)
                       && (32'(req.entry_index) < ENTRIES);
    assign last_op   = q_reg.use_plane ? OP_DOT_Z : OP_SQ_Z;
    assign done_step = 3'(last_op) + 3'd1;
    assign scan_last = (CW'(idx_reg + 1'b1) == n_reg);

    // front side test on the finished dot sum; flip mirrors the plane
    assign front = q_reg.plane_flip ? (dot[DOT_W-1] || (dot == '0)) : !dot[DOT_W-1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            radius_sq_reg   <= RADIUS_SQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_RADIUS_SQ:   radius_sq_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.req_type == REQ_QUERY))
                begin
                    if (entry_count_reg == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MAC;
            ST_MAC:
            begin
                if (step_reg == done_step)
                    state_next = ST_CMP;
            end
            ST_CMP:  state_next = scan_last ? ST_FIN : ST_READ;
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_ready       = 1'b0;
        rd_en           = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.op     = mac_op_t'(step_reg);
        rank_init       = 1'b0;
        rank_upd        = 1'b0;
        rsp_load        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                rank_init = req_acc && (req.req_type == REQ_QUERY);
            end
            ST_READ:
            begin
                rd_en          = 1'b1;
                mac_ctrl.clear = 1'b1;
            end
            ST_MAC:  mac_ctrl.mul_en = (step_reg <= 3'(last_op));
            ST_CMP:  rank_upd = 1'b1;
            ST_FIN:  rsp_load = !rsp_valid_reg || rsp_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rank_init)
            begin
                idx_reg <= '0;
                // clamp the count at the table size
                n_reg   <= (32'(entry_count_reg) > ENTRIES) ? NONE : CW'(entry_count_reg);
            end
            else if (rank_upd)
            begin
                idx_reg <= CW'(idx_reg + 1'b1);
            end
            if (state_reg == ST_MAC)
                step_reg <= 3'(step_reg + 3'd1);
            else
                step_reg <= '0;
        end
    end

    // hold the query for the whole scan
    always_ff @(posedge clk)
    begin
        if (rank_init)
            q_reg <= req;
    end

    // entry table: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AW'(req.entry_index)] <= {req.pos_x, req.pos_y, req.pos_z};
        if (rd_en)
            rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    tnps_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .query   (q_reg),
        .origin  (rd_data_reg),
        .dist_sq (dist_sq),
        .dot     (dot)
    );

    tnps_rank #(
        .CW      (CW),
        .ENTRIES (ENTRIES)
    ) u_rank_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (rank_init),
        .upd        (rank_upd),
        .cand_ok    (front),
        .cand_dist  (dist_sq),
        .cand_idx   (idx_reg),
        .radius_sq  (radius_sq_reg),
        .first_idx  (fr_first),
        .second_idx (fr_second)
    );

    tnps_rank #(
        .CW      (CW),
        .ENTRIES (ENTRIES)
    ) u_rank_all (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (rank_init),
        .upd        (rank_upd),
        .cand_ok    (1'b1),
        .cand_dist  (dist_sq),
        .cand_idx   (idx_reg),
        .radius_sq  (radius_sq_reg),
        .first_idx  (al_first),
        .second_idx (al_second)
    );

    // pick the front answer if the plane is in use and a front entry qualified, else the all-entries answer
    always_comb
    begin
        if (q_reg.use_plane && (fr_first != NONE))
        begin
            result.first_index   = IDX_W'(fr_first);
            result.second_index  = IDX_W'((fr_second == NONE) ? fr_first : fr_second);
            result.used_fallback = 1'b0;
        end
        else
        begin
            result.first_index   = IDX_W'(al_first);
            result.second_index  = IDX_W'((al_second == NONE) ? al_first : al_second);
            result.used_fallback = q_reg.use_plane;
        end
    end

    // response register: hold the item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // scan index stays inside the searched range
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (idx_reg < n_reg))
        else $error("scan index beyond searched range");

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && rsp_valid_reg && !rsp_ready) |=> (state_reg == ST_FIN))
        else $error("result left FIN while response register full");

    // multiply sequence always starts from a fresh table read
    a_mac_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && step_reg == 3'd0) |-> ($past(state_reg) == ST_READ))
        else $error("MAC started without a table read");

    // no second pick without a first
    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        (al_first == NONE) |-> (al_second == NONE))
        else $error("second pick present without first");

endmodule
